// ===== rtl/ptat_pkg.sv =====
`default_nettype none

package ptat_pkg;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int PID_W   = 22;
   localparam int MEM_W   = 40;
   localparam int DESC_W  = 20;
   localparam int TALLY_W = 16;
   localparam int CSR_W   = 40;
   localparam int CSR_IDX_W = 2;

   // Packed stream widths
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 48;

   // Table sizes
   localparam int ALERT_SLOTS_DEFAULT  = 64;
   localparam int PARENT_SLOTS_DEFAULT = 64;

   // Register reset values
   localparam logic [MEM_W-1:0]   MEM_LIMIT_RESET   = MEM_W'(500000);
   localparam logic [DESC_W-1:0]  DESC_LIMIT_RESET  = DESC_W'(100);
   localparam logic [TALLY_W-1:0] CHILD_LIMIT_RESET = TALLY_W'(30);

   // Only parents above this pid are reported
   localparam logic [PID_W-1:0]   PARENT_FLOOR = PID_W'(100);
   localparam logic [TALLY_W-1:0] TALLY_MAX    = '1;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MEMORY_LIMIT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DESCRIPTOR_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHILD_LIMIT      = 2'd2;

   // Result kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_BEGIN  = 2'd1,
      CMD_END    = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAR_RD,
      ST_PAR_EV,
      ST_ALR_RD,
      ST_ALR_EV,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_EMIT,
      ST_CLR,
      ST_END_RD,
      ST_END_EV,
      ST_REP_RD,
      ST_REP_EV,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/ptat_ram.sv =====
`default_nettype none

module ptat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/process_threshold_alert_tracker.sv =====
// Process threshold alert tracker.
// req channel: one transaction per command. tuser carries the command (sample,
// begin scan cycle, end scan cycle); tdata carries the sample fields. req_tready
// is high only while the sequencer is idle, so one command is worked at a time.
// rsp channel: a sample gives one verdict (tuser = 0, tlast = 1); an end of scan
// gives one fork report per qualifying parent (tuser = 1), tlast on the final one.
// Begin and unused commands give nothing.
// Walks: every table entry visit is a RAM read state, then an evaluate state.
//   sample : parent walk, then alert walk (dropping a cleared alert), then verdict
//   begin  : one seen mark cleared per cycle
//   end    : alert walk dropping unseen alerts, then parent walk; rsp stalls hold it
// The alert and parent RAMs each have one read port and one write port.
// A result sits in an output register, so the sequencer returns to idle and
// takes the next command while rsp_tready is low; a later result waits for the
// register to empty before it is written.
// Reset (synchronous) empties both tables and restores the limit registers;
// no clearing pass is needed, entries past the fill counts are never read.
// The user writes limits via csr_* only when idle; the block does not enforce it.
`default_nettype none

module process_threshold_alert_tracker #(
   parameter int ALERT_SLOTS  = ptat_pkg::ALERT_SLOTS_DEFAULT,
   parameter int PARENT_SLOTS = ptat_pkg::PARENT_SLOTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // fields, lowest bit up: proc_id, parent_id, memory_kb, descriptor_count
   input  wire logic [ptat_pkg::REQ_DATA_W-1:0]     req_tdata,
   // fields: cmd
   input  wire logic [ptat_pkg::CMD_W-1:0]          req_tuser,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // fields, lowest bit up: memory_alert, descriptor_alert, alerted, new_alert,
   // report_parent, child_count, zero fill
   output logic      [ptat_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // fields: kind
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_we,
   input  wire logic [ptat_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ptat_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int PID_W   = ptat_pkg::PID_W;
   localparam int TALLY_W = ptat_pkg::TALLY_W;
   localparam int AUW = $clog2(ALERT_SLOTS + 1);
   localparam int AAW = (ALERT_SLOTS > 1) ? $clog2(ALERT_SLOTS) : 1;
   localparam int PUW = $clog2(PARENT_SLOTS + 1);
   localparam int PAW = (PARENT_SLOTS > 1) ? $clog2(PARENT_SLOTS) : 1;
   localparam int PRW = PID_W + TALLY_W;

   // ---------------------------------------------------------------- registers
   ptat_pkg::state_type state_ff, state_in;
   ptat_pkg::cmd_type   cmd_ff, cmd_in;

   logic [ptat_pkg::MEM_W-1:0]  mem_limit_ff, mem_limit_in;
   logic [ptat_pkg::DESC_W-1:0] desc_limit_ff, desc_limit_in;
   logic [TALLY_W-1:0]          child_limit_ff, child_limit_in;

   logic [PID_W-1:0] pid_ff, pid_in;
   logic [PID_W-1:0] ppid_ff, ppid_in;
   logic             mem_alert_ff, mem_alert_in;
   logic             desc_alert_ff, desc_alert_in;
   logic             fresh_ff, fresh_in;

   logic [AUW-1:0] a_used_ff, a_used_in;
   logic [AUW-1:0] a_idx_ff, a_idx_in;
   logic [AAW-1:0] a_slot_ff, a_slot_in;
   logic [PUW-1:0] p_used_ff, p_used_in;
   logic [PUW-1:0] p_idx_ff, p_idx_in;

   // one fork report held back until the next one shows whether it is the last
   logic               pend_valid_ff, pend_valid_in;
   logic [PID_W-1:0]   pend_key_ff, pend_key_in;
   logic [TALLY_W-1:0] pend_tally_ff, pend_tally_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [3:0]         rsp_flags_ff, rsp_flags_in;
   logic [PID_W-1:0]   rsp_parent_ff, rsp_parent_in;
   logic [TALLY_W-1:0] rsp_count_ff, rsp_count_in;

   // ---------------------------------------------------------------- RAM ports
   logic             apid_we, aseen_we, a_re;
   logic [AAW-1:0]   a_waddr, a_raddr;
   logic [PID_W-1:0] apid_wdata, apid_rdata;
   logic             aseen_wdata, aseen_rdata;
   logic             par_we, par_re;
   logic [PAW-1:0]   par_waddr, par_raddr;
   logic [PRW-1:0]   par_wdata, par_rdata;

   // ---------------------------------------------------------------- decode
   logic               accept;
   logic               a_more, p_more, out_free;
   logic               alerted;
   logic [AAW-1:0]     a_last_idx;
   logic [AUW-1:0]     a_used_dec;
   logic [PID_W-1:0]   par_key;
   logic [TALLY_W-1:0] par_tally;
   logic [TALLY_W-1:0] par_tally_inc;
   logic               key_hit, pid_hit, report_hit;

   assign accept        = req_tvalid && req_tready;
   assign req_tready    = (state_ff == ptat_pkg::ST_IDLE);
   assign a_more        = (a_idx_ff < a_used_ff);
   assign p_more        = (p_idx_ff < p_used_ff);
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign alerted       = mem_alert_ff || desc_alert_ff;
   assign a_used_dec    = a_used_ff - AUW'(1);
   assign a_last_idx    = a_used_dec[AAW-1:0];
   assign par_key       = par_rdata[PID_W-1:0];
   assign par_tally     = par_rdata[PRW-1:PID_W];
   assign par_tally_inc = (par_tally == ptat_pkg::TALLY_MAX) ? par_tally
                                                             : par_tally + TALLY_W'(1);
   assign key_hit       = (par_key == ppid_ff);
   assign pid_hit       = (apid_rdata == pid_ff);
   assign report_hit    = (par_tally > child_limit_ff) && (par_key > ptat_pkg::PARENT_FLOOR);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptat_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  ptat_pkg::CMD_SAMPLE: state_in = ptat_pkg::ST_PAR_RD;
                  ptat_pkg::CMD_BEGIN:  state_in = ptat_pkg::ST_CLR;
                  ptat_pkg::CMD_END:    state_in = ptat_pkg::ST_END_RD;
                  default:              state_in = ptat_pkg::ST_IDLE;
               endcase
            end
         end
         ptat_pkg::ST_PAR_RD:  state_in = p_more ? ptat_pkg::ST_PAR_EV : ptat_pkg::ST_ALR_RD;
         ptat_pkg::ST_PAR_EV:  state_in = key_hit ? ptat_pkg::ST_ALR_RD : ptat_pkg::ST_PAR_RD;
         ptat_pkg::ST_ALR_RD:  state_in = a_more ? ptat_pkg::ST_ALR_EV : ptat_pkg::ST_EMIT;
         ptat_pkg::ST_ALR_EV: begin
            if (!pid_hit) begin
               state_in = ptat_pkg::ST_ALR_RD;
            end else if (alerted) begin
               state_in = ptat_pkg::ST_EMIT;
            end else begin
               state_in = ptat_pkg::ST_MOVE_RD;
            end
         end
         ptat_pkg::ST_MOVE_RD: state_in = ptat_pkg::ST_MOVE_WR;
         ptat_pkg::ST_MOVE_WR: begin
            state_in = (cmd_ff == ptat_pkg::CMD_END) ? ptat_pkg::ST_END_RD : ptat_pkg::ST_EMIT;
         end
         ptat_pkg::ST_EMIT:    state_in = out_free ? ptat_pkg::ST_IDLE : ptat_pkg::ST_EMIT;
         ptat_pkg::ST_CLR:     state_in = a_more ? ptat_pkg::ST_CLR : ptat_pkg::ST_IDLE;
         ptat_pkg::ST_END_RD:  state_in = a_more ? ptat_pkg::ST_END_EV : ptat_pkg::ST_REP_RD;
         ptat_pkg::ST_END_EV:  state_in = aseen_rdata ? ptat_pkg::ST_END_RD : ptat_pkg::ST_MOVE_RD;
         ptat_pkg::ST_REP_RD:  state_in = p_more ? ptat_pkg::ST_REP_EV : ptat_pkg::ST_FLUSH;
         ptat_pkg::ST_REP_EV: begin
            if (report_hit && pend_valid_ff && !out_free) begin
               state_in = ptat_pkg::ST_REP_EV;
            end else begin
               state_in = ptat_pkg::ST_REP_RD;
            end
         end
         ptat_pkg::ST_FLUSH: begin
            if (pend_valid_ff && !out_free) begin
               state_in = ptat_pkg::ST_FLUSH;
            end else begin
               state_in = ptat_pkg::ST_IDLE;
            end
         end
         default: state_in = ptat_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      cmd_in         = cmd_ff;
      mem_limit_in   = mem_limit_ff;
      desc_limit_in  = desc_limit_ff;
      child_limit_in = child_limit_ff;
      pid_in         = pid_ff;
      ppid_in        = ppid_ff;
      mem_alert_in   = mem_alert_ff;
      desc_alert_in  = desc_alert_ff;
      fresh_in       = fresh_ff;
      a_used_in      = a_used_ff;
      a_idx_in       = a_idx_ff;
      a_slot_in      = a_slot_ff;
      p_used_in      = p_used_ff;
      p_idx_in       = p_idx_ff;
      pend_valid_in  = pend_valid_ff;
      pend_key_in    = pend_key_ff;
      pend_tally_in  = pend_tally_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_flags_in   = rsp_flags_ff;
      rsp_parent_in  = rsp_parent_ff;
      rsp_count_in   = rsp_count_ff;

      apid_we     = 1'b0;
      aseen_we    = 1'b0;
      a_waddr     = a_idx_ff[AAW-1:0];
      apid_wdata  = pid_ff;
      aseen_wdata = 1'b1;
      a_re        = 1'b0;
      a_raddr     = a_idx_ff[AAW-1:0];
      par_we      = 1'b0;
      par_waddr   = p_idx_ff[PAW-1:0];
      par_wdata   = {par_tally_inc, ppid_ff};
      par_re      = 1'b0;
      par_raddr   = p_idx_ff[PAW-1:0];

      if (csr_we) begin
         case (csr_index)
            ptat_pkg::CSR_MEMORY_LIMIT:     mem_limit_in   = csr_wdata;
            ptat_pkg::CSR_DESCRIPTOR_LIMIT: desc_limit_in  = csr_wdata[ptat_pkg::DESC_W-1:0];
            ptat_pkg::CSR_CHILD_LIMIT:      child_limit_in = csr_wdata[TALLY_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ptat_pkg::ST_IDLE: begin
            if (accept) begin
               // latch the sample and compare against the limits on the way in
               cmd_in        = ptat_pkg::cmd_type'(req_tuser);
               pid_in        = req_tdata[PID_W-1:0];
               ppid_in       = req_tdata[2*PID_W-1:PID_W];
               mem_alert_in  = req_tdata[2*PID_W+ptat_pkg::MEM_W-1:2*PID_W] > mem_limit_ff;
               desc_alert_in = req_tdata[ptat_pkg::REQ_DATA_W-1:2*PID_W+ptat_pkg::MEM_W]
                               > desc_limit_ff;
               fresh_in      = 1'b0;
               a_idx_in      = '0;
               p_idx_in      = '0;
               pend_valid_in = 1'b0;
               if (req_tuser == ptat_pkg::CMD_BEGIN) begin
                  p_used_in = '0;
               end
            end
         end
         ptat_pkg::ST_PAR_RD: begin
            if (p_more) begin
               par_re = 1'b1;
            end else if (p_used_ff < PUW'(PARENT_SLOTS)) begin
               // unknown parent with room left: open an entry at count one
               par_we    = 1'b1;
               par_waddr = p_used_ff[PAW-1:0];
               par_wdata = {TALLY_W'(1), ppid_ff};
               p_used_in = p_used_ff + PUW'(1);
            end
         end
         ptat_pkg::ST_PAR_EV: begin
            if (key_hit) begin
               par_we = 1'b1;
            end else begin
               p_idx_in = p_idx_ff + PUW'(1);
            end
         end
         ptat_pkg::ST_ALR_RD: begin
            if (a_more) begin
               a_re = 1'b1;
            end else if (alerted) begin
               // pid not tracked: report as new, store it if the table has room
               fresh_in = 1'b1;
               if (a_used_ff < AUW'(ALERT_SLOTS)) begin
                  apid_we   = 1'b1;
                  aseen_we  = 1'b1;
                  a_waddr   = a_used_ff[AAW-1:0];
                  a_used_in = a_used_ff + AUW'(1);
               end
            end
         end
         ptat_pkg::ST_ALR_EV: begin
            if (!pid_hit) begin
               a_idx_in = a_idx_ff + AUW'(1);
            end else if (alerted) begin
               aseen_we = 1'b1;
            end else begin
               a_slot_in = a_idx_ff[AAW-1:0];
            end
         end
         ptat_pkg::ST_MOVE_RD: begin
            a_re    = 1'b1;
            a_raddr = a_last_idx;
         end
         ptat_pkg::ST_MOVE_WR: begin
            // fill the freed slot with the last entry and shrink the table
            apid_we     = 1'b1;
            aseen_we    = 1'b1;
            a_waddr     = a_slot_ff;
            apid_wdata  = apid_rdata;
            aseen_wdata = aseen_rdata;
            a_used_in   = a_used_dec;
         end
         ptat_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ptat_pkg::KIND_SAMPLE;
               rsp_last_in   = 1'b1;
               rsp_flags_in  = {fresh_ff, alerted, desc_alert_ff, mem_alert_ff};
               rsp_parent_in = '0;
               rsp_count_in  = '0;
            end
         end
         ptat_pkg::ST_CLR: begin
            if (a_more) begin
               aseen_we    = 1'b1;
               aseen_wdata = 1'b0;
               a_idx_in    = a_idx_ff + AUW'(1);
            end
         end
         ptat_pkg::ST_END_RD: begin
            if (a_more) begin
               a_re = 1'b1;
            end
         end
         ptat_pkg::ST_END_EV: begin
            if (aseen_rdata) begin
               a_idx_in = a_idx_ff + AUW'(1);
            end else begin
               // unseen: drop it and examine the same slot again
               a_slot_in = a_idx_ff[AAW-1:0];
            end
         end
         ptat_pkg::ST_REP_RD: begin
            if (p_more) begin
               par_re = 1'b1;
            end
         end
         ptat_pkg::ST_REP_EV: begin
            if (!report_hit) begin
               p_idx_in = p_idx_ff + PUW'(1);
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = ptat_pkg::KIND_REPORT;
                  rsp_last_in   = 1'b0;
                  rsp_flags_in  = '0;
                  rsp_parent_in = pend_key_ff;
                  rsp_count_in  = pend_tally_ff;
               end
               pend_valid_in = 1'b1;
               pend_key_in   = par_key;
               pend_tally_in = par_tally;
               p_idx_in      = p_idx_ff + PUW'(1);
            end
         end
         ptat_pkg::ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ptat_pkg::KIND_REPORT;
               rsp_last_in   = 1'b1;
               rsp_flags_in  = '0;
               rsp_parent_in = pend_key_ff;
               rsp_count_in  = pend_tally_ff;
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ptat_pkg::ST_IDLE;
         mem_limit_ff   <= ptat_pkg::MEM_LIMIT_RESET;
         desc_limit_ff  <= ptat_pkg::DESC_LIMIT_RESET;
         child_limit_ff <= ptat_pkg::CHILD_LIMIT_RESET;
         a_used_ff      <= '0;
         p_used_ff      <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mem_limit_ff   <= mem_limit_in;
         desc_limit_ff  <= desc_limit_in;
         child_limit_ff <= child_limit_in;
         a_used_ff      <= a_used_in;
         p_used_ff      <= p_used_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pid_ff        <= pid_in;
      ppid_ff       <= ppid_in;
      mem_alert_ff  <= mem_alert_in;
      desc_alert_ff <= desc_alert_in;
      fresh_ff      <= fresh_in;
      a_idx_ff      <= a_idx_in;
      a_slot_ff     <= a_slot_in;
      p_idx_ff      <= p_idx_in;
      pend_key_ff   <= pend_key_in;
      pend_tally_ff <= pend_tally_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_flags_ff  <= rsp_flags_in;
      rsp_parent_ff <= rsp_parent_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ---------------------------------------------------------------- tables
   ptat_ram #(.WIDTH(PID_W), .DEPTH(ALERT_SLOTS)) u_alert_pid (
      .clock   (clock),
      .wr_en   (apid_we),
      .wr_addr (a_waddr),
      .wr_data (apid_wdata),
      .rd_en   (a_re),
      .rd_addr (a_raddr),
      .rd_data (apid_rdata)
   );

   ptat_ram #(.WIDTH(1), .DEPTH(ALERT_SLOTS)) u_alert_seen (
      .clock   (clock),
      .wr_en   (aseen_we),
      .wr_addr (a_waddr),
      .wr_data (aseen_wdata),
      .rd_en   (a_re),
      .rd_addr (a_raddr),
      .rd_data (aseen_rdata)
   );

   ptat_ram #(.WIDTH(PRW), .DEPTH(PARENT_SLOTS)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_en   (par_re),
      .rd_addr (par_raddr),
      .rd_data (par_rdata)
   );

   // ---------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(ptat_pkg::RSP_DATA_W - 4 - PID_W - TALLY_W)'(0),
                        rsp_count_ff, rsp_parent_ff, rsp_flags_ff};

endmodule

`default_nettype wire

// ===== rtl/ptat_checker.sv =====
`default_nettype none

module ptat_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic [ptat_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tuser,
   input wire logic                            rsp_tlast,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready
);

   // a sample verdict is always the only result of its transaction
   a_sample_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ptat_pkg::KIND_SAMPLE) |-> rsp_tlast)
      else $error("sample verdict without tlast");

   // fork reports carry no alert flags
   a_report_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ptat_pkg::KIND_REPORT) |-> (rsp_tdata[3:0] == 4'b0000))
      else $error("fork report with alert flags set");

   // alerted is the union of the two limit flags, new_alert needs alerted
   a_flag_union: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[2] == (rsp_tdata[0] || rsp_tdata[1]))
                      && (!rsp_tdata[3] || rsp_tdata[2])))
      else $error("inconsistent alert flags");

   // a verdict has no parent or count fields
   a_sample_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ptat_pkg::KIND_SAMPLE) |-> (rsp_tdata[41:4] == '0))
      else $error("sample verdict with report fields");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("result changed while stalled");

endmodule

bind process_threshold_alert_tracker ptat_checker u_ptat_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

// ===== bench/tb_process_threshold_alert_tracker.sv =====
module tb_process_threshold_alert_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   import ptat_pkg::*;

   // Table depths as built into the block (defaults)
   localparam int ALERT_DEPTH  = ALERT_SLOTS_DEFAULT;
   localparam int PARENT_DEPTH = PARENT_SLOTS_DEFAULT;

   // Unused command code: the block drops it without a result
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int          PID_MAX   = 4194303;
   localparam logic [63:0] MEM_MASK  = 64'hFF_FFFF_FFFF;
   localparam logic [63:0] DESC_MASK = 64'hF_FFFF;
   localparam logic [MEM_W-1:0]  MEM_MAX  = '1;
   localparam logic [DESC_W-1:0] DESC_MAX = '1;

   // Guard for the worst walk of a command that returns nothing: an end of
   // scan with both tables full and every alert dropped.
   localparam int IDLE_GUARD_CYCLES = 400;
   // Receiver hold-off used to back the block up into its input
   localparam int LONG_HOLD_CYCLES  = 300;
   // Cycles without any transaction before the run is declared hung
   localparam int QUIET_LIMIT       = 4000;

   // One result as seen on the rsp side: {tuser, tlast, tdata}
   typedef struct packed {
      logic                kind;
      logic                last;
      logic [5:0]          fill;
      logic [TALLY_W-1:0]  child_count;
      logic [PID_W-1:0]    report_parent;
      logic                new_alert;
      logic                alerted;
      logic                desc_alert;
      logic                mem_alert;
   } verdict_t;

   logic clock;
   logic reset = 1'b1;

   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   // Knobs shared between the stimulus and the receiver
   bit idle_on  = 1'b1;   // random gaps on both sides
   bit hold_req = 1'b0;   // toggle to request one long receiver hold-off

   int mismatches  = 0;
   int quiet_cycles = 0;

   // Verdicts and fork reports still owed by the block, oldest first
   verdict_t pending_verdicts[$];

   // Shadow of the limit registers
   logic [MEM_W-1:0]   limit_mem_kb   = MEM_LIMIT_RESET;
   logic [DESC_W-1:0]  limit_desc     = DESC_LIMIT_RESET;
   logic [TALLY_W-1:0] limit_children = CHILD_LIMIT_RESET;

   // Shadow of the alert table and the per-parent tally table
   logic [PID_W-1:0]   alert_ids     [ALERT_DEPTH];
   bit                 alert_marks   [ALERT_DEPTH];
   int                 alerts_used   = 0;
   logic [PID_W-1:0]   parent_ids    [PARENT_DEPTH];
   logic [TALLY_W-1:0] parent_counts [PARENT_DEPTH];
   int                 parents_used  = 0;

   process_threshold_alert_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Free an alert slot: pull the last valid entry down into it
   function automatic void retire_alert(int slot);
      alert_ids[slot]   = alert_ids[alerts_used - 1];
      alert_marks[slot] = alert_marks[alerts_used - 1];
      alerts_used--;
   endfunction

   // Advance the shadow tables by one accepted command and queue the
   // results it owes.
   function automatic void evaluate_scan_command(logic [CMD_W-1:0] cmd,
                                                 logic [PID_W-1:0] pid,
                                                 logic [PID_W-1:0] ppid,
                                                 logic [MEM_W-1:0] mem_kb,
                                                 logic [DESC_W-1:0] desc);
      verdict_t v;
      int       slot;
      int       reports;
      int       i;
      bit       found;
      logic     mem_hit;
      logic     desc_hit;

      v = '0;
      if (cmd == CMD_SAMPLE) begin
         mem_hit  = mem_kb > limit_mem_kb;
         desc_hit = desc > limit_desc;

         // Tally the parent; a full table drops parents it has not seen
         found = 1'b0;
         for (i = 0; i < parents_used; i++) begin
            if (!found && parent_ids[i] == ppid) begin
               found = 1'b1;
               if (parent_counts[i] != TALLY_MAX)
                  parent_counts[i]++;
            end
         end
         if (!found && parents_used < PARENT_DEPTH) begin
            parent_ids[parents_used]    = ppid;
            parent_counts[parents_used] = 1;
            parents_used++;
         end

         slot = -1;
         for (i = 0; i < alerts_used; i++)
            if (slot < 0 && alert_ids[i] == pid)
               slot = i;

         if (!(mem_hit || desc_hit)) begin
            if (slot >= 0)
               retire_alert(slot);
         end else if (slot >= 0) begin
            alert_marks[slot] = 1'b1;
         end else begin
            // Not tracked: new, and stored only while there is room
            v.new_alert = 1'b1;
            if (alerts_used < ALERT_DEPTH) begin
               alert_ids[alerts_used]   = pid;
               alert_marks[alerts_used] = 1'b1;
               alerts_used++;
            end
         end
         v.kind       = KIND_SAMPLE;
         v.mem_alert  = mem_hit;
         v.desc_alert = desc_hit;
         v.alerted    = mem_hit || desc_hit;
         v.last       = 1'b1;
         pending_verdicts.push_back(v);
      end else if (cmd == CMD_BEGIN) begin
         for (i = 0; i < alerts_used; i++)
            alert_marks[i] = 1'b0;
         parents_used = 0;
      end else if (cmd == CMD_END) begin
         // Expire unseen alerts in slot order; recheck a slot after a move
         i = 0;
         while (i < alerts_used) begin
            if (!alert_marks[i])
               retire_alert(i);
            else
               i++;
         end
         reports = 0;
         for (i = 0; i < parents_used; i++) begin
            if (parent_counts[i] > limit_children && parent_ids[i] > PARENT_FLOOR) begin
               v               = '0;
               v.kind          = KIND_REPORT;
               v.report_parent = parent_ids[i];
               v.child_count   = parent_counts[i];
               pending_verdicts.push_back(v);
               reports++;
            end
         end
         if (reports > 0) begin
            v      = pending_verdicts.pop_back();
            v.last = 1'b1;
            pending_verdicts.push_back(v);
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic logic [PID_W-1:0] rand_pid();
      return PID_W'($urandom_range(0, PID_MAX));
   endfunction

   function automatic logic [MEM_W-1:0] rand_mem();
      return MEM_W'({$urandom, $urandom});
   endfunction

   // Land on, just past, just under, far under a limit, or anywhere in the mask
   function automatic logic [63:0] pick_near(logic [63:0] limit, logic [63:0] mask);
      case ($urandom_range(0, 4))
         0: return limit & mask;
         1: return (limit + 64'd1) & mask;
         2: return (limit - 64'd1) & mask;
         3: return 64'd0;
         default: return {$urandom, $urandom} & mask;
      endcase
   endfunction

   // Offer one command, hold it until the block takes it, then predict.
   // Enter and leave in the time step right after a rising edge.
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                               logic [PID_W-1:0] ppid, logic [MEM_W-1:0] mem_kb,
                               logic [DESC_W-1:0] desc);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {desc, mem_kb, ppid, pid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      evaluate_scan_command(cmd, pid, ppid, mem_kb, desc);
   endtask

   // Begin, end and unused commands carry junk in tdata
   task automatic send_event(logic [CMD_W-1:0] cmd);
      send_command(cmd, rand_pid(), rand_pid(), rand_mem(), DESC_W'($urandom));
   endtask

   // Stop offering, wait out every owed result, then give the block time to
   // finish a walk that ends without a result.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (IDLE_GUARD_CYCLES) @(posedge clock);
   endtask

   // Write all three limits back to back; the block must be idle
   task automatic program_limits(logic [MEM_W-1:0] mem_kb, logic [DESC_W-1:0] desc,
                                 logic [TALLY_W-1:0] children);
      csr_we    <= 1'b1;
      csr_index <= CSR_MEMORY_LIMIT;
      csr_wdata <= CSR_W'(mem_kb);
      @(posedge clock);
      limit_mem_kb = mem_kb;
      csr_index <= CSR_DESCRIPTOR_LIMIT;
      csr_wdata <= CSR_W'(desc);
      @(posedge clock);
      limit_desc = desc;
      csr_index <= CSR_CHILD_LIMIT;
      csr_wdata <= CSR_W'(children);
      @(posedge clock);
      limit_children = children;
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Limits straight out of reset: compare right at and just past each one,
   // repeat an alert, clear one, and let a scan expire the rest.
   task automatic test_reset_limits();
      send_command(CMD_SAMPLE, 1, 1, MEM_LIMIT_RESET, DESC_LIMIT_RESET);
      send_command(CMD_SAMPLE, 2, 1, MEM_LIMIT_RESET + 1, 0);
      send_command(CMD_SAMPLE, 2, 1, 0, DESC_LIMIT_RESET + 1);   // still tracked
      send_command(CMD_SAMPLE, 3, 1, MEM_MAX, DESC_MAX);
      send_command(CMD_SAMPLE, 2, 1, 0, 0);                      // clears pid 2
      send_command(CMD_SAMPLE, 2, 1, MEM_LIMIT_RESET + 1, 0);    // new once more
      send_event(CMD_BEGIN);
      send_event(CMD_UNUSED);
      send_event(CMD_END);                                        // expires both
      send_command(CMD_SAMPLE, 3, 1, MEM_MAX, 0);
   endtask

   // Zero and full-scale limits, pid and parent extremes, the parent floor
   task automatic test_limit_extremes();
      settle_block();
      program_limits('0, '0, '0);
      send_event(CMD_BEGIN);
      send_command(CMD_SAMPLE, 0, PARENT_FLOOR, 0, 0);
      send_command(CMD_SAMPLE, PID_W'(PID_MAX), PARENT_FLOOR + 1, 1, 0);
      send_command(CMD_SAMPLE, 5, PID_W'(PID_MAX), 0, 1);
      send_command(CMD_SAMPLE, 6, PARENT_FLOOR + 1, MEM_MAX, DESC_MAX);
      send_command(CMD_SAMPLE, PID_W'(PID_MAX), 0, 0, 0);
      send_event(CMD_END);
      settle_block();
      program_limits(MEM_MAX, DESC_MAX, TALLY_MAX);
      send_command(CMD_SAMPLE, 7, PARENT_FLOOR + 2, MEM_MAX, DESC_MAX);
      send_command(CMD_SAMPLE, 5, PARENT_FLOOR + 2, MEM_MAX, DESC_MAX);
      send_event(CMD_UNUSED);
      send_event(CMD_END);
   endtask

   // Scan expiry: only alerts seen since the last begin survive an end,
   // including the case where the entry moved into a freed slot is unseen too.
   task automatic test_scan_expiry();
      int k;
      settle_block();
      program_limits(MEM_LIMIT_RESET, DESC_LIMIT_RESET, CHILD_LIMIT_RESET);
      send_event(CMD_BEGIN);
      send_event(CMD_END);
      send_event(CMD_BEGIN);
      for (k = 10; k < 15; k++)
         send_command(CMD_SAMPLE, k, 0, 0, 200);
      send_event(CMD_END);
      send_event(CMD_BEGIN);
      send_command(CMD_SAMPLE, 11, 0, 0, 200);
      send_event(CMD_END);
      for (k = 10; k < 15; k++)
         send_command(CMD_SAMPLE, k, 0, 0, 200);
      send_event(CMD_BEGIN);
      send_command(CMD_SAMPLE, 11, 0, 0, 200);
      send_command(CMD_SAMPLE, 13, 0, 0, 200);
      send_event(CMD_END);
      send_command(CMD_SAMPLE, 12, 0, 0, 200);
      send_command(CMD_SAMPLE, 13, 0, 0, 200);
   endtask

   // Overfill the alert table: the overflow keeps coming back as new until
   // a slot frees up.
   task automatic test_alert_table_full();
      int k;
      settle_block();
      program_limits(MEM_LIMIT_RESET, 10, CHILD_LIMIT_RESET);
      send_event(CMD_BEGIN);
      for (k = 0; k < ALERT_DEPTH + 2; k++)
         send_command(CMD_SAMPLE, 1000 + k, 50, 0, 11);
      send_command(CMD_SAMPLE, 1000 + ALERT_DEPTH, 50, 0, 11);
      send_command(CMD_SAMPLE, 1000, 50, 0, 11);
      send_command(CMD_SAMPLE, 1030, 50, 0, 0);
      send_command(CMD_SAMPLE, 1000 + ALERT_DEPTH + 1, 50, 0, 11);
      send_command(CMD_SAMPLE, 1000 + ALERT_DEPTH + 1, 50, 0, 11);
      send_command(CMD_SAMPLE, 1000 + ALERT_DEPTH, 50, 0, 11);
      send_event(CMD_BEGIN);
      send_event(CMD_END);
      send_command(CMD_SAMPLE, 1000, 50, 0, 11);
   endtask

   // Overfill the parent table with a zero child limit: the end of scan
   // returns the largest burst of reports, and late parents go uncounted.
   task automatic test_parent_table_full();
      int k;
      settle_block();
      program_limits(MEM_MAX, DESC_MAX, '0);
      send_event(CMD_BEGIN);
      for (k = 0; k < PARENT_DEPTH + 4; k++)
         send_command(CMD_SAMPLE, rand_pid(), 101 + k, rand_mem(), DESC_W'($urandom));
      send_command(CMD_SAMPLE, rand_pid(), 101, 0, 0);
      send_command(CMD_SAMPLE, rand_pid(), 101 + PARENT_DEPTH - 1, 0, 0);
      send_command(CMD_SAMPLE, rand_pid(), 101 + PARENT_DEPTH + 3, 0, 0);
      send_event(CMD_END);
   endtask

   // Hold the receiver off for a long stretch while the sender keeps
   // offering back to back, so the output register fills and req stalls.
   task automatic test_output_backpressure();
      int k;
      settle_block();
      program_limits(1000, 50, 1);
      idle_on = 1'b0;
      send_event(CMD_BEGIN);
      hold_req = ~hold_req;
      for (k = 0; k < 20; k++)
         send_command(CMD_SAMPLE, rand_pid(), 200 + (k % 3),
                      MEM_W'(pick_near(1000, MEM_MASK)), DESC_W'(pick_near(50, DESC_MASK)));
      send_event(CMD_END);
      send_command(CMD_SAMPLE, rand_pid(), 200, 0, 0);
      settle_block();
      idle_on = 1'b1;
   endtask

   // Drive one parent past the top of its tally; the report must stop at
   // the saturated count.
   task automatic test_tally_saturation();
      int k;
      settle_block();
      program_limits(MEM_MAX, DESC_MAX, TALLY_MAX - 1);
      idle_on = 1'b0;
      // Empty the alert table first so every sample walks short tables
      send_event(CMD_BEGIN);
      send_event(CMD_END);
      send_event(CMD_BEGIN);
      for (k = 0; k < 65537; k++)
         send_command(CMD_SAMPLE, rand_pid(), 777, 0, 0);
      send_event(CMD_END);
      settle_block();
      idle_on = 1'b1;
   endtask

   // Random scan cycles: mostly begin, samples, end with content drawn near
   // the current limits from small pid and parent pools so alerts repeat and
   // parents cross the child limit; mixed with stray events and junk commands.
   task automatic test_random_scans();
      logic [PID_W-1:0] pid_pool    [12];
      logic [PID_W-1:0] parent_pool [6];
      logic [PID_W-1:0] pid;
      logic [PID_W-1:0] ppid;
      int               phase;
      int               k;
      int               count;

      for (k = 0; k < 12; k++)
         pid_pool[k] = rand_pid();
      parent_pool[0] = PID_W'($urandom_range(0, 100));
      parent_pool[1] = PARENT_FLOOR;
      parent_pool[2] = PARENT_FLOOR + 1;
      for (k = 3; k < 6; k++)
         parent_pool[k] = PID_W'($urandom_range(101, PID_MAX));

      for (phase = 0; phase < 9; phase++) begin
         settle_block();
         case (phase)
            0: program_limits(MEM_MAX, DESC_MAX, TALLY_MAX);
            1: program_limits('0, '0, '0);
            default: program_limits(rand_mem(), DESC_W'($urandom),
                                    TALLY_W'($urandom_range(0, 3)));
         endcase
         // Every third phase runs flat out on both sides
         idle_on = (phase % 3) != 2;
         if ($urandom_range(0, 9) != 0)
            send_event(CMD_BEGIN);
         count = $urandom_range(16, 24);
         for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
               0: send_event(CMD_UNUSED);
               1: send_event($urandom_range(0, 1) ? CMD_BEGIN : CMD_END);
               default: begin
                  pid  = ($urandom_range(0, 4) == 0) ? rand_pid()
                                                     : pid_pool[$urandom_range(0, 11)];
                  ppid = ($urandom_range(0, 4) == 0) ? rand_pid()
                                                     : parent_pool[$urandom_range(0, 5)];
                  send_command(CMD_SAMPLE, pid, ppid,
                               MEM_W'(pick_near(64'(limit_mem_kb), MEM_MASK)),
                               DESC_W'(pick_near(64'(limit_desc), DESC_MASK)));
               end
            endcase
         end
         send_event(CMD_END);
      end
      settle_block();
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, one long hold-off on request, and the check
   // of every rsp transaction against the oldest owed verdict.
   // ---------------------------------------------------------------------
   initial begin : rsp_sink
      int       wait_cycles;
      bit       hold_ack;
      verdict_t seen;
      verdict_t want;

      hold_ack = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_ack != hold_req) begin
            hold_ack    = hold_req;
            wait_cycles = LONG_HOLD_CYCLES;
         end else begin
            wait_cycles = idle_on ? $urandom_range(0, 4) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);

         seen = {rsp_tuser, rsp_tlast, rsp_tdata};
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result kind=%0d last=%0d tdata=%h",
                     $time, rsp_tuser, rsp_tlast, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            if (seen !== want) begin
               $display({"%0t: result mismatch\n",
                         "  expected kind=%0d last=%0d mem=%0d desc=%0d alerted=%0d",
                         " new=%0d parent=%0d count=%0d fill=%0d\n",
                         "  actual   kind=%0d last=%0d mem=%0d desc=%0d alerted=%0d",
                         " new=%0d parent=%0d count=%0d fill=%0d"},
                        $time,
                        want.kind, want.last, want.mem_alert, want.desc_alert,
                        want.alerted, want.new_alert, want.report_parent,
                        want.child_count, want.fill,
                        seen.kind, seen.last, seen.mem_alert, seen.desc_alert,
                        seen.alerted, seen.new_alert, seen.report_parent,
                        seen.child_count, seen.fill);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: reset the count on any transaction, end the run if the
   // bench goes quiet for far longer than any legal walk or stall.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("process_threshold_alert_tracker regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin : run
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_limits();
      test_limit_extremes();
      test_scan_expiry();
      test_alert_table_full();
      test_parent_table_full();
      test_output_backpressure();
      test_tally_saturation();
      test_random_scans();

      // Drain whatever is still owed before judging
      settle_block();
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("process_threshold_alert_tracker regression: pass");
      end else begin
         $display("process_threshold_alert_tracker regression: fail");
      end
      $finish;
   end

endmodule
